>>> rtl/mtbg_pkg.sv
// Shared types, constants and the tempering function of the MT19937 byte generator.
package mtbg_pkg;

    // Store geometry and twist offsets
    localparam int STATE_WORDS = 624;
    localparam int SHIFT_M     = 397;
    localparam int WRAP_M      = STATE_WORDS - SHIFT_M;
    localparam int ADDR_W      = $clog2(STATE_WORDS);
    localparam int COUNT_W     = 7;

    // Recurrence and tempering constants
    localparam logic [31:0] TW_MATRIX   = 32'h9908_B0DF;
    localparam logic [31:0] TW_TEMPER_B = 32'h9D2C_5680;
    localparam logic [31:0] TW_TEMPER_C = 32'hEFC6_0000;
    localparam logic [31:0] TW_INIT_MUL = 32'd1812433253;
    localparam logic [31:0] TW_UPPER    = 32'h8000_0000;
    localparam logic [31:0] TW_LOWER    = 32'h7FFF_FFFF;

    // Command codes
    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    // One classified command as it sits in the queue
    typedef struct packed {
        logic               reseed;
        logic [COUNT_W-1:0] count;
    } cmd_entry_t;

    // Standard MT19937 output tempering
    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TW_TEMPER_B);
        y = y ^ ((y << 15) & TW_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

>>> rtl/mtbg_cmd_queue.sv
// Front end: takes requests, classifies them and holds them in a two-entry queue.
module mtbg_cmd_queue #(
    parameter int MAX_BYTES_PER_DRAW = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          cmd,
    input  logic [mtbg_pkg::COUNT_W-1:0]  count,
    output logic                          head_valid,
    output mtbg_pkg::cmd_entry_t          head,
    input  logic                          head_pop
);

    localparam logic [mtbg_pkg::COUNT_W-1:0] MAX_CNT =
        mtbg_pkg::COUNT_W'(MAX_BYTES_PER_DRAW);

    mtbg_pkg::cmd_entry_t ent_reg [2];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           fill_reg;
    mtbg_pkg::cmd_entry_t entry;
    logic                 transfer;
    logic                 push;

    // Classify: saturate the count, drop draws of zero bytes
    always_comb
    begin
        entry.reseed = (cmd == mtbg_pkg::CMD_RESEED);
        entry.count  = (count > MAX_CNT) ? MAX_CNT : count;
    end

    assign req_stall  = (fill_reg == 2'd2);
    assign transfer   = req_valid && !req_stall;
    assign push       = transfer && (entry.reseed || (count != '0));
    assign head_valid = (fill_reg != 2'd0);
    assign head       = ent_reg[rd_ptr_reg];

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= entry;
        end
    end

    // Queue pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (head_pop && head_valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !(head_pop && head_valid))
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (!push && head_pop && head_valid)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 2'd2)
        else $error("queue fill level out of range");
`endif

endmodule

>>> rtl/mtbg_engine.sv
// Back end: state store, seeding sequencer, twist/temper and byte output register.
module mtbg_engine #(
    parameter int MAX_BYTES_PER_DRAW = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [31:0]          seed,
    input  logic                 head_valid,
    input  mtbg_pkg::cmd_entry_t head,
    output logic                 head_pop,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [7:0]           data_byte,
    output logic                 last
);

    localparam int LEFT_W = $clog2(MAX_BYTES_PER_DRAW + 1);
    localparam int AW     = mtbg_pkg::ADDR_W;

    localparam logic [AW-1:0] LAST_IDX = AW'(mtbg_pkg::STATE_WORDS - 1);
    localparam logic [AW-1:0] WRAP_IDX = AW'(mtbg_pkg::WRAP_M);
    localparam logic [AW-1:0] SHIFT_IDX = AW'(mtbg_pkg::SHIFT_M);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SEED0 = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_ACK   = 3'd4;
    localparam logic [2:0] S_RD    = 3'd5;
    localparam logic [2:0] S_TW    = 3'd6;
    localparam logic [2:0] S_BYTE  = 3'd7;

    logic [31:0]       mem [mtbg_pkg::STATE_WORDS];
    logic [31:0]       rd_a_reg;
    logic [31:0]       rd_b_reg;

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     word_index_reg, word_index_next;
    logic [AW-1:0]     fill_idx_reg, fill_idx_next;
    logic [2:0]        pending_reg, pending_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic [31:0]       rem_reg, rem_next;
    logic [31:0]       cur_word_reg, cur_word_next;
    logic [31:0]       v_reg, v_next;
    logic [31:0]       prod_reg, prod_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        byte_reg, byte_next;
    logic              last_reg, last_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [31:0]       mem_wdata;
    logic [AW-1:0]     k1;
    logic [AW-1:0]     km;
    logic [31:0]       tw_x;
    logic [31:0]       tw_xa;
    logic [31:0]       tw_new;
    logic              out_free;

    // Neighbor addresses of the entry being twisted
    assign k1 = (word_index_reg == LAST_IDX) ? '0 : word_index_reg + AW'(1);
    assign km = (word_index_reg >= WRAP_IDX) ? word_index_reg - WRAP_IDX
                                             : word_index_reg + SHIFT_IDX;

    // Twist: upper bit from entry k (cached), lower bits from k+1, xor entry k+397
    assign tw_x   = (cur_word_reg & mtbg_pkg::TW_UPPER) | (rd_a_reg & mtbg_pkg::TW_LOWER);
    assign tw_xa  = (tw_x >> 1) ^ (tw_x[0] ? mtbg_pkg::TW_MATRIX : 32'd0);
    assign tw_new = rd_b_reg ^ tw_xa;

    assign out_free = !out_valid_reg || !rsp_stall;
    assign head_pop = (state_reg == S_IDLE) && head_valid;

    // Store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= mem[k1];
        rd_b_reg <= mem[km];
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        word_index_next = word_index_reg;
        fill_idx_next   = fill_idx_reg;
        pending_next    = pending_reg;
        left_next       = left_reg;
        rem_next        = rem_reg;
        cur_word_next   = cur_word_reg;
        v_next          = v_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        byte_next       = byte_reg;
        last_next       = last_reg;
        mem_we          = 1'b0;
        mem_waddr       = word_index_reg;
        mem_wdata       = tw_new;

        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    if (head.reseed)
                    begin
                        state_next = S_SEED0;
                    end
                    else
                    begin
                        left_next  = LEFT_W'(head.count);
                        state_next = (pending_reg == 3'd0) ? S_RD : S_BYTE;
                    end
                end
            end
            S_SEED0:
            begin
                // Write entry zero and clear the word position
                mem_we          = 1'b1;
                mem_waddr       = '0;
                mem_wdata       = seed;
                v_next          = seed;
                cur_word_next   = seed;
                fill_idx_next   = AW'(1);
                word_index_next = '0;
                pending_next    = 3'd0;
                rem_next        = 32'd0;
                state_next      = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = mtbg_pkg::TW_INIT_MUL * (v_reg ^ (v_reg >> 30));
                state_next = S_ADD;
            end
            S_ADD:
            begin
                mem_we        = 1'b1;
                mem_waddr     = fill_idx_reg;
                mem_wdata     = prod_reg + 32'(fill_idx_reg);
                v_next        = prod_reg + 32'(fill_idx_reg);
                fill_idx_next = fill_idx_reg + AW'(1);
                state_next    = (fill_idx_reg == LAST_IDX) ? S_ACK : S_MUL;
            end
            S_ACK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    byte_next      = 8'd0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RD:
            begin
                // Wait for the registered reads of entries k+1 and k+397
                state_next = S_TW;
            end
            S_TW:
            begin
                mem_we          = 1'b1;
                cur_word_next   = rd_a_reg;
                word_index_next = k1;
                rem_next        = mtbg_pkg::temper(tw_new);
                pending_next    = 3'd4;
                state_next      = S_BYTE;
            end
            S_BYTE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    byte_next      = rem_reg[7:0];
                    last_next      = (left_reg == LEFT_W'(1));
                    rem_next       = rem_reg >> 8;
                    pending_next   = pending_reg - 3'd1;
                    left_next      = left_reg - LEFT_W'(1);
                    if (left_reg == LEFT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else if (pending_reg == 3'd1)
                    begin
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            word_index_reg <= '0;
            fill_idx_reg   <= '0;
            pending_reg    <= 3'd0;
            left_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            word_index_reg <= word_index_next;
            fill_idx_reg   <= fill_idx_next;
            pending_reg    <= pending_next;
            left_reg       <= left_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        cur_word_reg <= cur_word_next;
        v_reg        <= v_next;
        prod_reg     <= prod_next;
        byte_reg     <= byte_next;
        last_reg     <= last_next;
    end

    assign rsp_valid = out_valid_reg;
    assign data_byte = byte_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        word_index_reg <= LAST_IDX)
        else $error("word index beyond the store");

    a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("too many pending bytes");

    a_fetch_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> (pending_reg == 3'd0))
        else $error("word fetch while bytes remain");

    a_twist_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TW) |=> (pending_reg == 3'd4) && (state_reg == S_BYTE))
        else $error("twist did not refill the byte buffer");
`endif

endmodule

>>> rtl/mt19937_byte_generator_unit.sv
// Top level of the MT19937 byte generator: seed register, command queue and engine.
//
//  channel   direction  handshake              payload
//  request   in         req_valid / req_stall  cmd, count
//  response  out        rsp_valid / rsp_stall  data_byte, last
//  config    in         cfg_we                 cfg_wdata (seed)
//
// A draw takes the command, then per fresh 32-bit word a registered store read, then a
// twist and temper; one byte leaves per cycle between fetches while the response is not
// stalled. A reseed fills each store entry past the first by a multiply, then an add.
// Reset clears control state; the store is undefined until the first reseed.
// A stalled response holds the engine; two queued commands stall the request side.
module mt19937_byte_generator_unit #(
    parameter int MAX_BYTES_PER_DRAW = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [31:0]                  cfg_wdata,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic                         cmd,
    input  logic [mtbg_pkg::COUNT_W-1:0] count,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [7:0]                   data_byte,
    output logic                         last
);

    logic [31:0]          seed_reg;
    logic                 head_valid;
    logic                 head_pop;
    mtbg_pkg::cmd_entry_t head;

    // Seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            seed_reg <= cfg_wdata;
        end
    end

    mtbg_cmd_queue #(
        .MAX_BYTES_PER_DRAW (MAX_BYTES_PER_DRAW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .cmd        (cmd),
        .count      (count),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    mtbg_engine #(
        .MAX_BYTES_PER_DRAW (MAX_BYTES_PER_DRAW)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed       (seed_reg),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .data_byte  (data_byte),
        .last       (last)
    );

endmodule
